// ===== design/pli_pkg.sv =====
// Shared widths, codes and state type of the piecewise linear interpolator.
`default_nettype none
package pli_pkg;

    // Field widths of one item
    localparam int unsigned ANGLE_W   = 15;
    localparam int unsigned VALUE_W   = 16;
    localparam int unsigned QUERY_W   = 16;
    localparam int unsigned INDEX_W   = 4;
    localparam int unsigned COUNT_W   = 5;

    // Divider widths: product of angle span and value step, 16-bit quotient
    localparam int unsigned PROD_W    = ANGLE_W + VALUE_W;
    localparam int unsigned QUO_W     = VALUE_W;
    localparam int unsigned STEP_W    = $clog2(QUO_W + 1);

    // pi/2 in Q1.14
    localparam logic [ANGLE_W-1:0] HALF_PI_Q14 = 15'd25736;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_LAUNCH,
        S_DIV
    } t_state;

endpackage
`default_nettype wire

// ===== design/pli_divider.sv =====
// Restoring divider, one quotient bit per cycle, quotient known to fit in QUO_W bits.
`default_nettype none
module pli_divider
    import pli_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [PROD_W-1:0]  i_dividend,
    input  wire logic [ANGLE_W-1:0] i_divisor,
    output logic                    o_done,
    output logic [QUO_W-1:0]        o_quotient
);

    logic [VALUE_W-1:0] r_rem;
    logic [QUO_W-1:0]   r_quo;
    logic [ANGLE_W-1:0] r_div;
    logic [STEP_W-1:0]  r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [VALUE_W-1:0] shifted;
    logic               fits;

    // Shift in the next dividend bit and trial-subtract the divisor
    assign shifted = {r_rem[VALUE_W-2:0], r_quo[QUO_W-1]};
    assign fits    = shifted >= {1'b0, r_div};

    // Control: count steps, pulse done after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(QUO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: upper dividend bits are already below the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_dividend[PROD_W-1:QUO_W]};
            r_quo <= i_dividend[QUO_W-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? (shifted - {1'b0, r_div}) : shifted;
            r_quo <= {r_quo[QUO_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

// ===== design/piecewise_linear_interpolator.sv =====
// Piecewise linear interpolation table: breakpoint memory, serial search, iterative divide.
// Write item: busy stays low; it produces no result.
// Query: busy while slots are scanned, one memory read each. A hit on slot 0 returns its value,
// a miss past the last slot returns zero; any other hit goes through the launch state and the
// QUO_W (16) divider steps, then the result strobe follows. Empty table: strobe with busy low.
// Reset clears the count register and control; the breakpoint memory is not cleared.
`default_nettype none
module piecewise_linear_interpolator
    import pli_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [COUNT_W-1:0] i_cfg_data,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_command,
    input  wire logic [INDEX_W-1:0] i_entry_index,
    input  wire logic [ANGLE_W-1:0] i_entry_angle,
    input  wire logic [VALUE_W-1:0] i_entry_value,
    input  wire logic [QUERY_W-1:0] i_query_angle,
    output logic                    o_valid,
    output logic [VALUE_W-1:0]      o_value,
    output logic                    o_in_range
);

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned ENT_W = ANGLE_W + VALUE_W;

    t_state r_state, n_state;

    logic [COUNT_W-1:0] r_entry_count;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [ANGLE_W-1:0] r_q, n_q;
    logic [ANGLE_W-1:0] r_prev_angle, n_prev_angle;
    logic [VALUE_W-1:0] r_prev_value, n_prev_value;
    logic [ANGLE_W-1:0] r_num, n_num;
    logic [ANGLE_W-1:0] r_den, n_den;
    logic [VALUE_W-1:0] r_diff, n_diff;
    logic               r_neg, n_neg;
    logic               r_valid, n_valid;
    logic [VALUE_W-1:0] r_value, n_value;
    logic               r_in_range, n_in_range;

    logic [ENT_W-1:0]   mem [TABLE_DEPTH];
    logic [ENT_W-1:0]   r_rd_data;
    logic [ANGLE_W-1:0] rd_angle;
    logic [VALUE_W-1:0] rd_value;

    logic               accept;
    logic               mem_we;
    logic [ANGLE_W-1:0] q_clamp;
    logic [CNT_W-1:0]   count_sat;
    logic               hit;
    logic               last;
    logic [PROD_W-1:0]  div_dividend;
    logic               div_done;
    logic [QUO_W-1:0]   div_quo;

    assign accept  = start && !busy;
    assign busy    = (r_state != S_IDLE);
    assign mem_we  = accept && (i_command == CMD_WRITE) && (32'(i_entry_index) < TABLE_DEPTH);

    // Clamp the query angle and saturate the count
    assign q_clamp   = (i_query_angle > {1'b0, HALF_PI_Q14}) ? HALF_PI_Q14
                                                            : i_query_angle[ANGLE_W-1:0];
    assign count_sat = (32'(r_entry_count) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                          : CNT_W'(r_entry_count);

    assign rd_angle = r_rd_data[ENT_W-1:VALUE_W];
    assign rd_value = r_rd_data[VALUE_W-1:0];
    assign hit      = rd_angle >= r_q;
    assign last     = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;

    // Count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_data;
        end
    end

    // Breakpoint memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[IDX_W'(i_entry_index)] <= {i_entry_angle, i_entry_value};
        end
        r_rd_data <= mem[n_idx];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_command == CMD_QUERY) && (count_sat != '0)) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    n_state = (r_idx == '0) ? S_IDLE : S_LAUNCH;
                end else if (last) begin
                    n_state = S_IDLE;
                end
            end
            S_LAUNCH: n_state = S_DIV;
            S_DIV: begin
                if (div_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and result
    always_comb begin
        n_idx        = r_idx;
        n_count      = r_count;
        n_q          = r_q;
        n_prev_angle = r_prev_angle;
        n_prev_value = r_prev_value;
        n_num        = r_num;
        n_den        = r_den;
        n_diff       = r_diff;
        n_neg        = r_neg;
        n_valid      = 1'b0;
        n_value      = r_value;
        n_in_range   = r_in_range;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_command == CMD_QUERY)) begin
                    n_q     = q_clamp;
                    n_count = count_sat;
                    n_idx   = '0;
                    if (count_sat == '0) begin
                        n_valid    = 1'b1;
                        n_value    = '0;
                        n_in_range = 1'b0;
                    end
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    if (r_idx == '0) begin
                        n_valid    = 1'b1;
                        n_value    = rd_value;
                        n_in_range = 1'b1;
                    end else begin
                        // previous slot lies strictly below the query
                        n_num = r_q - r_prev_angle;
                        n_den = rd_angle - r_prev_angle;
                        if (rd_value >= r_prev_value) begin
                            n_diff = rd_value - r_prev_value;
                            n_neg  = 1'b0;
                        end else begin
                            n_diff = r_prev_value - rd_value;
                            n_neg  = 1'b1;
                        end
                    end
                end else if (last) begin
                    n_valid    = 1'b1;
                    n_value    = '0;
                    n_in_range = 1'b0;
                end else begin
                    n_prev_angle = rd_angle;
                    n_prev_value = rd_value;
                    n_idx        = r_idx + IDX_W'(1);
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_valid    = 1'b1;
                    n_value    = r_neg ? (r_prev_value - div_quo) : (r_prev_value + div_quo);
                    n_in_range = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_count      <= n_count;
        r_q          <= n_q;
        r_prev_angle <= n_prev_angle;
        r_prev_value <= n_prev_value;
        r_num        <= n_num;
        r_den        <= n_den;
        r_diff       <= n_diff;
        r_neg        <= n_neg;
        r_value      <= n_value;
        r_in_range   <= n_in_range;
    end

    // Scale the value step by the angle offset; the divider registers the product
    assign div_dividend = {{VALUE_W{1'b0}}, r_num} * {{ANGLE_W{1'b0}}, r_diff};

    pli_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_LAUNCH),
        .i_dividend (div_dividend),
        .i_divisor  (r_den),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_valid    = r_valid;
    assign o_value    = r_value;
    assign o_in_range = r_in_range;

    // A result only appears once the block is back to idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_valid |-> !busy)
        else $error("result strobe while busy");

    // Divider finishes only while the sequencer waits for it
    assert property (@(posedge i_clk) disable iff (!i_rst_n) div_done |-> (r_state == S_DIV))
        else $error("divider done outside divide state");

    // A miss always reports a zero value
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_in_range) |-> (o_value == '0))
        else $error("out-of-range result with nonzero value");

    // A write beat never yields a result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_command == CMD_WRITE)) |=> !o_valid)
        else $error("result after write beat");

endmodule
`default_nettype wire
